>>> rtl/teq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package teq_pkg;
   localparam int TimeWidth = 32;
   localparam int IdWidth   = 16;
   localparam int KindWidth = 3;
   localparam int CountWidth = 5;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_FIRED   = 3'd0,
      KIND_DONE    = 3'd1,
      KIND_PAST    = 3'd2,
      KIND_FULL    = 3'd3,
      KIND_REMOVED = 3'd4
   } kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the request fields
      logic scan_clear;  // load the read/write scan pointers for a new scan
      logic scan_step;   // process one slot of the scan
      logic add_commit;  // write the new event at the open slot
      logic time_add;    // advance current time
      logic pop_commit;  // finish a remove or advance compaction
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       scan_done;   // scan pointer reached occupancy, or zero on add
      logic       is_past;
      logic       is_full;
      logic       slot_due;    // slot at the scan pointer is due
      logic       slot_match;  // slot at the scan pointer matches remove time
      logic       slot_after;  // slot below the scan pointer is after the new event
   } dp_status_type;
endpackage
`default_nettype wire

>>> rtl/teq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module teq_datapath #(
   parameter int DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire teq_pkg::dp_cmd_type           cmd,
   input  wire logic [1:0]                    op_sel,
   input  wire logic [31:0]                   req_event_time,
   input  wire logic [15:0]                   req_event_id,
   input  wire logic [31:0]                   req_remove_time,
   input  wire logic [31:0]                   req_advance_amount,
   output teq_pkg::dp_status_type             status,
   output logic [15:0]                        slot_id_out,
   output logic [31:0]                        slot_time_out,
   output logic [$clog2(DEPTH+1)-1:0]         removed_out
);
   import teq_pkg::*;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // The store is swept slot by slot; add walks from the top shifting
   // entries up, remove and advance compact from the bottom.
   logic [TimeWidth-1:0] time_mem [DEPTH];
   logic [IdWidth-1:0]   id_mem   [DEPTH];

   logic [CW-1:0]  occ_ff, occ_in;
   logic [31:0]    now_ff, now_in;
   logic [CW-1:0]  rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0]     op_ff;
   logic [31:0]    ev_time_ff, rm_time_ff, amount_ff;
   logic [15:0]    ev_id_ff;
   logic           firing_ff, firing_in;

   logic [AW-1:0]  rd_idx, wr_idx, below_idx;
   logic [31:0]    rd_time, below_time;
   logic [15:0]    rd_id, below_id;
   logic           is_add;

   assign is_add    = (op_ff == OP_ADD);
   // For add, rd counts down from occupancy: the candidate is rd-1.
   assign below_idx = AW'(rd_ff - CW'(1));
   assign rd_idx    = rd_ff[AW-1:0];
   assign wr_idx    = wr_ff[AW-1:0];
   assign rd_time   = time_mem[rd_idx];
   assign rd_id     = id_mem[rd_idx];
   assign below_time = time_mem[below_idx];
   assign below_id   = id_mem[below_idx];

   always_comb begin
      status.is_past    = ev_time_ff < now_ff;
      status.is_full    = occ_ff >= CW'(DEPTH);
      status.scan_done  = is_add ? (rd_ff == '0) : (rd_ff >= occ_ff);
      status.slot_after = below_time > ev_time_ff;
      status.slot_match = rd_time == rm_time_ff;
      status.slot_due   = firing_ff && (rd_time <= now_ff);
   end

   assign slot_id_out   = rd_id;
   assign slot_time_out = rd_time;
   assign removed_out   = CW'(rd_ff - wr_ff);

   always_comb begin
      occ_in    = occ_ff;
      now_in    = now_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      firing_in = firing_ff;
      if (cmd.time_add) begin
         now_in = now_ff + amount_ff;
      end
      if (cmd.scan_clear) begin
         rd_in     = is_add ? occ_ff : '0;
         wr_in     = is_add ? occ_ff : '0;
         firing_in = 1'b1;
      end
      if (cmd.scan_step) begin
         if (is_add) begin
            rd_in = rd_ff - CW'(1);
            wr_in = wr_ff - CW'(1);
         end else begin
            rd_in = rd_ff + CW'(1);
            if (op_ff == OP_REMOVE) begin
               if (!status.slot_match) wr_in = wr_ff + CW'(1);
            end else if (!status.slot_due) begin
               wr_in     = wr_ff + CW'(1);
               firing_in = 1'b0;
            end
         end
      end
      if (cmd.add_commit) occ_in = occ_ff + CW'(1);
      if (cmd.pop_commit) occ_in = wr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         now_ff    <= '0;
         rd_ff     <= '0;
         wr_ff     <= '0;
         op_ff     <= OP_NONE;
         firing_ff <= 1'b0;
      end else begin
         occ_ff    <= occ_in;
         now_ff    <= now_in;
         rd_ff     <= rd_in;
         wr_ff     <= wr_in;
         firing_ff <= firing_in;
         if (cmd.capture) op_ff <= op_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ev_time_ff <= req_event_time;
         ev_id_ff   <= req_event_id;
         rm_time_ff <= req_remove_time;
         amount_ff  <= req_advance_amount;
      end
      if (cmd.scan_step) begin
         if (is_add) begin
            time_mem[wr_idx] <= below_time;
            id_mem[wr_idx]   <= below_id;
         end else if (op_ff == OP_REMOVE ? !status.slot_match : !status.slot_due) begin
            time_mem[wr_idx] <= rd_time;
            id_mem[wr_idx]   <= rd_id;
         end
      end
      if (cmd.add_commit) begin
         time_mem[wr_idx] <= ev_time_ff;
         id_mem[wr_idx]   <= ev_id_ff;
      end
   end
endmodule
`default_nettype wire

>>> rtl/teq_control.sv
`timescale 1ns / 1ps
`default_nettype none
module teq_control (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [1:0]            op_sel,
   input  wire teq_pkg::dp_status_type status,
   output teq_pkg::dp_cmd_type        cmd,
   output logic                       busy,
   output logic                       emit_fire,
   output logic                       emit_done,
   output teq_pkg::kind_type          done_kind
);
   import teq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_ADD_SCAN, S_REM_SCAN, S_ADV_SCAN, S_FINISH
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   kind_type  kind_ff;
   logic [1:0] op_ff;

   assign busy = busy_ff;

   always_comb begin
      cmd = '0;
      emit_fire = 1'b0;
      emit_done = 1'b0;
      done_kind = kind_ff;
      unique case (state_ff)
         S_IDLE: cmd.capture = start;
         S_DECODE: begin
            cmd.scan_clear = 1'b1;
            cmd.time_add = (op_ff == OP_ADVANCE);
         end
         S_ADD_SCAN: begin
            if (!status.scan_done && status.slot_after) cmd.scan_step = 1'b1;
            else cmd.add_commit = 1'b1;
         end
         S_REM_SCAN: begin
            if (!status.scan_done) cmd.scan_step = 1'b1;
            else cmd.pop_commit = 1'b1;
         end
         S_ADV_SCAN: begin
            if (!status.scan_done) begin
               cmd.scan_step = 1'b1;
               emit_fire = status.slot_due;
            end else begin
               cmd.pop_commit = 1'b1;
            end
         end
         S_FINISH: emit_done = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         kind_ff  <= KIND_DONE;
         op_ff    <= OP_NONE;
      end else begin
         unique case (state_ff)
            S_IDLE: if (start) begin
               busy_ff  <= 1'b1;
               op_ff    <= op_sel;
               state_ff <= S_DECODE;
            end
            S_DECODE: begin
               case (op_ff)
                  OP_ADD: begin
                     if (status.is_past) begin
                        kind_ff <= KIND_PAST;
                        state_ff <= S_FINISH;
                     end else if (status.is_full) begin
                        kind_ff <= KIND_FULL;
                        state_ff <= S_FINISH;
                     end else begin
                        kind_ff <= KIND_DONE;
                        state_ff <= S_ADD_SCAN;
                     end
                  end
                  OP_REMOVE: begin
                     kind_ff <= KIND_REMOVED;
                     state_ff <= S_REM_SCAN;
                  end
                  OP_ADVANCE: begin
                     kind_ff <= KIND_DONE;
                     state_ff <= S_ADV_SCAN;
                  end
                  default: begin
                     kind_ff <= KIND_DONE;
                     state_ff <= S_FINISH;
                  end
               endcase
            end
            S_ADD_SCAN: if (status.scan_done || !status.slot_after) state_ff <= S_FINISH;
            S_REM_SCAN: if (status.scan_done) state_ff <= S_FINISH;
            S_ADV_SCAN: if (status.scan_done) state_ff <= S_FINISH;
            S_FINISH: begin
               busy_ff  <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/timed_event_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted queue of up to DEPTH timed events. A command is taken when start is
// high and busy is low. Its beats cannot be stalled: fired beats appear one
// per cycle on rsp_valid, and the final beat, with rsp_last set, follows the
// end of the sweep. An accepted add, a remove and an advance sweep the slot
// store one entry per cycle; a rejected add or an unused operation does not
// sweep. Busy falls in the same cycle as the last beat shows on the outputs,
// so the next command can be taken at the edge ending it.
module timed_event_queue_unit #(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_event_time,
   input  wire logic [15:0] req_event_id,
   input  wire logic [31:0] req_remove_time,
   input  wire logic [31:0] req_advance_amount,
   output logic             rsp_valid,
   output logic [2:0]       rsp_kind,
   output logic [15:0]      rsp_fired_id,
   output logic [31:0]      rsp_fired_time,
   output logic [4:0]       rsp_removed_count,
   output logic             rsp_last
);
   import teq_pkg::*;
   localparam int CW = $clog2(DEPTH + 1);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [15:0]   slot_id;
   logic [31:0]   slot_time;
   logic [CW-1:0] removed;
   logic          emit_fire, emit_done;
   kind_type      done_kind;
   logic          valid_ff;
   logic [2:0]    kind_ff;
   logic [15:0]   id_ff;
   logic [31:0]   time_ff;
   logic [4:0]    count_ff;
   logic          last_ff;

   teq_datapath #(.DEPTH(DEPTH)) u_dp (
      .clock, .reset, .cmd, .op_sel(req_operation),
      .req_event_time, .req_event_id, .req_remove_time, .req_advance_amount,
      .status, .slot_id_out(slot_id), .slot_time_out(slot_time),
      .removed_out(removed)
   );

   teq_control u_ctl (
      .clock, .reset, .start, .op_sel(req_operation), .status, .cmd, .busy,
      .emit_fire, .emit_done, .done_kind
   );

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= emit_fire || emit_done;
      kind_ff  <= emit_fire ? KIND_FIRED : done_kind;
      id_ff    <= emit_fire ? slot_id : '0;
      time_ff  <= emit_fire ? slot_time : '0;
      count_ff <= (emit_done && done_kind == KIND_REMOVED) ? 5'(removed) : '0;
      last_ff  <= emit_done;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_fired_id      = id_ff;
   assign rsp_fired_time    = time_ff;
   assign rsp_removed_count = count_ff;
   assign rsp_last          = last_ff;

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("command not taken");
   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> !emit_done) else $error("fire and done together");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      emit_done |=> !emit_fire && !emit_done) else $error("beat after last");
endmodule
`default_nettype wire

>>> verif/timed_event_queue_unit_tb.sv
`timescale 1ns / 1ps
module timed_event_queue_unit_tb;
   import teq_pkg::*;

   localparam int Depth = 16;

   typedef struct {
      logic [2:0]  kind;
      logic [15:0] id;
      logic [31:0] tm;
      logic [4:0]  count;
      logic        last;
   } beat_type;

   class event_queue_scoreboard;
      logic [31:0] due_time [$];
      logic [15:0] due_id [$];
      logic [31:0] now;
      beat_type    pending [$];
      int          errors;
      int          beats_seen;

      function void clear();
         due_time.delete();
         due_id.delete();
         now = '0;
         pending.delete();
         errors = 0;
         beats_seen = 0;
      endfunction

      function void push_beat(logic [2:0] k, logic [15:0] i, logic [31:0] t,
                              logic [4:0] c, logic l);
         beat_type b;
         b.kind = k;
         b.id = i;
         b.tm = t;
         b.count = c;
         b.last = l;
         pending.push_back(b);
      endfunction

      function void note_command(logic [1:0] op, logic [31:0] et, logic [15:0] eid,
                                 logic [31:0] rt, logic [31:0] amt);
         int pos;
         int removed;
         case (op)
            OP_ADD: begin
               if (et < now) begin
                  push_beat(KIND_PAST, '0, '0, '0, 1'b1);
               end else if (due_time.size() >= Depth) begin
                  push_beat(KIND_FULL, '0, '0, '0, 1'b1);
               end else begin
                  pos = 0;
                  while (pos < due_time.size() && due_time[pos] <= et) pos++;
                  due_time.insert(pos, et);
                  due_id.insert(pos, eid);
                  push_beat(KIND_DONE, '0, '0, '0, 1'b1);
               end
            end
            OP_REMOVE: begin
               removed = 0;
               for (int i = due_time.size() - 1; i >= 0; i--) begin
                  if (due_time[i] == rt) begin
                     due_time.delete(i);
                     due_id.delete(i);
                     removed++;
                  end
               end
               push_beat(KIND_REMOVED, '0, '0, 5'(removed), 1'b1);
            end
            OP_ADVANCE: begin
               now = now + amt;
               while (due_time.size() > 0 && due_time[0] <= now) begin
                  push_beat(KIND_FIRED, due_id[0], due_time[0], '0, 1'b0);
                  due_time.delete(0);
                  due_id.delete(0);
               end
               push_beat(KIND_DONE, '0, '0, '0, 1'b1);
            end
            default: push_beat(KIND_DONE, '0, '0, '0, 1'b1);
         endcase
      endfunction

      function void check_beat(beat_type got);
         beat_type exp;
         beats_seen++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat kind=%0d id=%h time=%h count=%0d last=%b",
                     $time, got.kind, got.id, got.tm, got.count, got.last);
            errors++;
            return;
         end
         exp = pending[0];
         pending.delete(0);
         if (exp.kind !== got.kind || exp.id !== got.id || exp.tm !== got.tm ||
             exp.count !== got.count || exp.last !== got.last) begin
            $display("%0t: mismatch expected kind=%0d id=%h time=%h count=%0d last=%b",
                     $time, exp.kind, exp.id, exp.tm, exp.count, exp.last);
            $display("%0t:          actual   kind=%0d id=%h time=%h count=%0d last=%b",
                     $time, got.kind, got.id, got.tm, got.count, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = '0;
   logic [31:0] req_event_time = '0;
   logic [15:0] req_event_id = '0;
   logic [31:0] req_remove_time = '0;
   logic [31:0] req_advance_amount = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_fired_id;
   logic [31:0] rsp_fired_time;
   logic [4:0]  rsp_removed_count;
   logic        rsp_last;

   event_queue_scoreboard queue_model;
   bit                    allow_gaps = 1'b1;
   logic [31:0]           recent_time [$];

   timed_event_queue_unit #(.DEPTH(Depth)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_event_time(req_event_time),
      .req_event_id(req_event_id), .req_remove_time(req_remove_time),
      .req_advance_amount(req_advance_amount), .rsp_valid(rsp_valid),
      .rsp_kind(rsp_kind), .rsp_fired_id(rsp_fired_id),
      .rsp_fired_time(rsp_fired_time), .rsp_removed_count(rsp_removed_count),
      .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      beat_type b;
      if (!reset && rsp_valid) begin
         b.kind = rsp_kind;
         b.id = rsp_fired_id;
         b.tm = rsp_fired_time;
         b.count = rsp_removed_count;
         b.last = rsp_last;
         queue_model.check_beat(b);
      end
   end

   task automatic issue(logic [1:0] op, logic [31:0] et, logic [15:0] eid,
                        logic [31:0] rt, logic [31:0] amt);
      int gap;
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_event_time <= et;
      req_event_id <= eid;
      req_remove_time <= rt;
      req_advance_amount <= amt;
      @(posedge clock);
      while (busy) @(posedge clock);
      // The command was taken at this edge; predict before any response arrives.
      queue_model.note_command(op, et, eid, rt, amt);
      start <= 1'b0;
      // The block is busy in the cycle after a command is taken.
      @(posedge clock);
   endtask

   task automatic drain();
      while (queue_model.pending.size() != 0) @(posedge clock);
      repeat (Depth + 8) @(posedge clock);
   endtask

   // Half adds, mostly near the current time, with removes mostly aimed at recently added times.
   task automatic random_command();
      int sel;
      logic [31:0] t;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         if ($urandom_range(0, 9) == 0) t = $urandom();
         else if ($urandom_range(0, 3) == 0 && recent_time.size() > 0)
            t = recent_time[$urandom_range(0, recent_time.size() - 1)];
         else t = queue_model.now + $urandom_range(0, 60) - 5;
         recent_time.push_back(t);
         if (recent_time.size() > 8) recent_time.delete(0);
         issue(OP_ADD, t, 16'($urandom()), $urandom(), $urandom());
      end else if (sel < 65) begin
         if (recent_time.size() > 0 && $urandom_range(0, 3) != 0)
            t = recent_time[$urandom_range(0, recent_time.size() - 1)];
         else t = $urandom();
         issue(OP_REMOVE, $urandom(), 16'($urandom()), t, $urandom());
      end else if (sel < 97) begin
         if ($urandom_range(0, 15) == 0) t = $urandom();
         else t = $urandom_range(0, 40);
         issue(OP_ADVANCE, $urandom(), 16'($urandom()), $urandom(), t);
      end else begin
         issue(OP_NONE, $urandom(), 16'($urandom()), $urandom(), $urandom());
      end
   endtask

   initial begin
      queue_model = new();
      queue_model.clear();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extremes of the fields and a same-time tie.
      issue(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, '0, '0);
      issue(OP_ADD, 32'd0, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(OP_ADD, 32'd5, 16'hAAAA, '0, '0);
      issue(OP_ADD, 32'd5, 16'h5555, '0, '0);
      issue(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(OP_REMOVE, '0, '0, 32'd5, '0);
      issue(OP_REMOVE, '0, '0, 32'd77, '0);
      issue(OP_ADVANCE, '0, '0, '0, 32'd0);
      issue(OP_ADVANCE, '0, '0, '0, 32'd10);
      // Fill the store, then an add that is full, then one both past and full.
      for (int i = 0; i < Depth; i++)
         issue(OP_ADD, 32'd20 + i, 16'(i), '0, '0);
      issue(OP_ADD, 32'd100, 16'h1234, '0, '0);
      issue(OP_ADD, 32'd1, 16'h4321, '0, '0);
      // Advance that wraps the current time around.
      issue(OP_ADVANCE, '0, '0, '0, 32'hFFFF_FFF8);
      // Sender holds off until every beat has come back.
      drain();
      issue(OP_ADVANCE, '0, '0, '0, 32'd40);

      for (int n = 0; n < 200; n++) begin
         if (n > 165) allow_gaps = 1'b0;
         random_command();
      end
      drain();

      $display("Ran directed and random add, remove, advance and unused commands;");
      $display("%0d response beats were checked.", queue_model.beats_seen);
      if (queue_model.errors == 0 && queue_model.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
